[rtl/core/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants, register codes and types of the weight stability detector.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int WINDOW_LENGTH_DEF = 16;
	localparam int WEIGHT_BITS_DEF   = 23;

	// fixed field widths
	localparam int SAMPLE_W   = 24;
	localparam int TIME_W     = 32;
	localparam int IN_DATA_W  = 56;  // sample_weight + now_ms, whole bytes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int JUMP_W     = 20;
	localparam int ALPHA_W    = 17;
	localparam int LEVEL_W    = 16;
	localparam int FRAC_W     = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
	localparam logic [FRAC_W-1:0]  HALF_LSB  = 16'd32768;

	// register reset values
	localparam logic [JUMP_W-1:0]  JUMP_RST     = 20'd800;
	localparam logic [ALPHA_W-1:0] ALPHA_RST    = 17'd22938;
	localparam logic [LEVEL_W-1:0] HOLD_RST     = 16'd500;
	localparam logic [LEVEL_W-1:0] FLOOR_RST    = 16'd50;
	localparam logic [LEVEL_W-1:0] PRESENCE_RST = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JUMP_THRESHOLD  = 3'd0,
		CFG_SMOOTHING_ALPHA = 3'd1,
		CFG_HOLD_TIME       = 3'd2,
		CFG_NOISE_FLOOR     = 3'd3,
		CFG_PRESENCE_LEVEL  = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLAIM  = 1'b1
	} op_t;

	// machine_state codes as seen on the result
	localparam logic [1:0] MS_IDLE      = 2'd0;
	localparam logic [1:0] MS_MEASURING = 2'd1;
	localparam logic [1:0] MS_STABLE    = 2'd2;
	localparam logic [1:0] MS_WAIT      = 2'd3;

	typedef struct packed {
		logic [JUMP_W-1:0]  jump_threshold;
		logic [ALPHA_W-1:0] smoothing_alpha;
		logic [LEVEL_W-1:0] hold_time;
		logic [LEVEL_W-1:0] noise_floor;
		logic [LEVEL_W-1:0] presence_level;
	} cfg_t;

endpackage

[rtl/core/wsd_ram.sv]
// ----------------------------------------------------------------------------
// wsd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/wsd_ring.sv]
// ----------------------------------------------------------------------------
// wsd_ring
// Input register, sample clamp, sample ring with running sum and fill flag.
// ----------------------------------------------------------------------------
module wsd_ring import wsd_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	localparam int IDX_W = $clog2(WINDOW_LENGTH),
	localparam int SUM_W = WEIGHT_BITS + IDX_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  op_t                        in_op,
	input  logic signed [SAMPLE_W-1:0] in_weight,
	input  logic [TIME_W-1:0]          in_now,
	output logic                       out_valid,
	input  logic                       out_ready,
	output op_t                        out_op,
	output logic                       out_upd,
	output logic [SUM_W-1:0]           out_sum,
	output logic [TIME_W-1:0]          out_now
);

	localparam logic [32:0]      W_MAX    = (33'd1 << WEIGHT_BITS) - 33'd1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LENGTH - 1);

	logic                   v_s1, v_s2;
	op_t                    op_s1;
	logic [WEIGHT_BITS-1:0] w_s1;
	logic [TIME_W-1:0]      now_s1;

	logic [IDX_W-1:0]       idx_q, idx_inc, idx_next;
	logic                   full_q, last;
	logic [SUM_W-1:0]       sum_q, sum_d;
	logic [WEIGHT_BITS-1:0] rd_data, old_w, w_clamp;
	logic [SAMPLE_W-1:0]    pos;
	logic                   fire1, take, wr;

	// negative -> 0, too large -> full scale
	assign pos     = in_weight[SAMPLE_W-1] ? '0 : in_weight;
	assign w_clamp = (33'(pos) > W_MAX) ? WEIGHT_BITS'(W_MAX) : WEIGHT_BITS'(pos);

	assign fire1    = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || fire1;
	assign take     = in_valid && in_ready;
	assign wr       = fire1 && (op_s1 == OP_SAMPLE);

	assign last     = (idx_q == IDX_LAST);
	assign idx_inc  = last ? '0 : idx_q + 1'b1;
	// read ahead at the slot the next sample replaces
	assign idx_next = wr ? idx_inc : idx_q;

	// slots not yet filled since reset read as zero
	assign old_w = full_q ? rd_data : '0;
	assign sum_d = sum_q - SUM_W'(old_w) + SUM_W'(w_s1);

	wsd_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(WINDOW_LENGTH)
	) u_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (idx_q),
		.wdata (w_s1),
		.raddr (idx_next),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			idx_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (!v_s2 || out_ready) begin
				v_s2 <= v_s1;
			end
			if (wr) begin
				idx_q  <= idx_inc;
				full_q <= full_q | last;
				sum_q  <= sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= in_op;
			w_s1   <= w_clamp;
			now_s1 <= in_now;
		end
		if (fire1) begin
			out_op  <= op_s1;
			out_upd <= (op_s1 == OP_SAMPLE) && (full_q || last);
			out_sum <= sum_d;
			out_now <= now_s1;
		end
	end

	assign out_valid = v_s2;

endmodule

[rtl/core/wsd_filter.sv]
// ----------------------------------------------------------------------------
// wsd_filter
// Window mean, noise floor and jump gate, exponential smoothing with a Q1.16 factor.
// ----------------------------------------------------------------------------
module wsd_filter import wsd_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	localparam int IDX_W = $clog2(WINDOW_LENGTH),
	localparam int SUM_W = WEIGHT_BITS + IDX_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  op_t                    in_op,
	input  logic                   in_upd,
	input  logic [SUM_W-1:0]       in_sum,
	input  logic [TIME_W-1:0]      in_now,
	output logic                   out_valid,
	input  logic                   out_ready,
	output op_t                    out_op,
	output logic                   out_upd,
	output logic [WEIGHT_BITS-1:0] out_weight,
	output logic [TIME_W-1:0]      out_now
);

	localparam int ACC_W = WEIGHT_BITS + FRAC_W;
	localparam int EW    = WEIGHT_BITS + ALPHA_W + 1;
	localparam int LW    = ALPHA_W + FRAC_W;
	localparam int CW    = (WEIGHT_BITS > JUMP_W ? WEIGHT_BITS : JUMP_W) + 1;

	logic [WEIGHT_BITS-1:0] mean;

	// sum / WINDOW_LENGTH, truncated
	if ((WINDOW_LENGTH & (WINDOW_LENGTH - 1)) == 0) begin : g_shift
		assign mean = WEIGHT_BITS'(in_sum >> IDX_W);
	end else begin : g_recip
		localparam int RS = SUM_W + IDX_W;
		localparam int PW = SUM_W + RS;
		localparam logic [63:0] RECIP =
			((64'd1 << RS) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
		logic [PW-1:0] prod;
		assign prod = PW'(in_sum) * PW'(RECIP[RS-1:0]);
		assign mean = WEIGHT_BITS'(prod >> RS);
	end

	logic                   v_s3, v_s4, v_s5;
	logic                   ready3, ready4, ready5, fire3, fire4;
	op_t                    op_s3, op_s4;
	logic                   upd_s3, upd_s4;
	logic [WEIGHT_BITS-1:0] mean_s3, am_s4;
	logic [TIME_W-1:0]      now_s3, now_s4;

	// accepted mean
	logic [WEIGHT_BITS-1:0] am_q, am_d, mean_z, diff;
	logic                   accept;

	assign mean_z = (CW'(mean_s3) < CW'(cfg.noise_floor)) ? '0 : mean_s3;
	assign diff   = (mean_z > am_q) ? mean_z - am_q : am_q - mean_z;
	assign accept = (am_q == '0) || (CW'(diff) <= CW'(cfg.jump_threshold));
	assign am_d   = accept ? mean_z : am_q;

	// smoothing: acc' = alpha*am + beta*acc_hi + ((beta*acc_lo + half) >> 16)
	logic [ACC_W-1:0]       acc_q, acc_d;
	logic [ALPHA_W-1:0]     alpha_sat, beta;
	logic [EW-1:0]          p_new, p_old, acc_sum;
	logic [LW-1:0]          p_low;
	logic [WEIGHT_BITS-1:0] w_new;

	assign alpha_sat = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
	assign beta      = ALPHA_ONE - alpha_sat;
	assign p_new     = EW'(alpha_sat) * EW'(am_s4);
	assign p_old     = EW'(beta) * EW'(acc_q[ACC_W-1:FRAC_W]);
	assign p_low     = LW'(beta) * LW'(acc_q[FRAC_W-1:0]) + LW'(HALF_LSB);
	assign acc_sum   = p_new + p_old + EW'(p_low >> FRAC_W);
	assign acc_d     = ACC_W'(acc_sum);
	assign w_new     = upd_s4 ? acc_d[ACC_W-1:FRAC_W] : acc_q[ACC_W-1:FRAC_W];

	assign ready5   = !v_s5 || out_ready;
	assign fire4    = v_s4 && ready5;
	assign ready4   = !v_s4 || fire4;
	assign fire3    = v_s3 && ready4;
	assign ready3   = !v_s3 || fire3;
	assign in_ready = ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			am_q  <= '0;
			acc_q <= '0;
		end else begin
			if (ready3) begin
				v_s3 <= in_valid;
			end
			if (ready4) begin
				v_s4 <= v_s3;
			end
			if (ready5) begin
				v_s5 <= v_s4;
			end
			if (fire3 && upd_s3) begin
				am_q <= am_d;
			end
			if (fire4 && upd_s4) begin
				acc_q <= acc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready3) begin
			op_s3   <= in_op;
			upd_s3  <= in_upd;
			mean_s3 <= mean;
			now_s3  <= in_now;
		end
		if (fire3) begin
			op_s4  <= op_s3;
			upd_s4 <= upd_s3;
			am_s4  <= am_d;
			now_s4 <= now_s3;
		end
		if (fire4) begin
			out_op     <= op_s4;
			out_upd    <= upd_s4;
			out_weight <= w_new;
			out_now    <= now_s4;
		end
	end

	assign out_valid = v_s5;

endmodule

[rtl/core/wsd_fsm.sv]
// ----------------------------------------------------------------------------
// wsd_fsm
// Presence / stability state machine, claim handling and result register.
// ----------------------------------------------------------------------------
module wsd_fsm import wsd_pkg::*; #(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  op_t                    in_op,
	input  logic                   in_upd,
	input  logic [WEIGHT_BITS-1:0] in_weight,
	input  logic [TIME_W-1:0]      in_now,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [WEIGHT_BITS-1:0] smoothed_weight,
	output logic [1:0]             machine_state,
	output logic                   holding,
	output logic                   item_granted,
	output logic [WEIGHT_BITS-1:0] item_weight
);

	localparam int CW = (WEIGHT_BITS > JUMP_W ? WEIGHT_BITS : JUMP_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE      = MS_IDLE,
		S_MEASURING = MS_MEASURING,
		S_STABLE    = MS_STABLE,
		S_WAIT      = MS_WAIT
	} state_t;

	state_t                 state_q, state_d;
	logic [WEIGHT_BITS-1:0] ref_q, ref_d, held_q, held_d, diff;
	logic [TIME_W-1:0]      start_q, start_d, start_eff;
	logic                   bsv_q, bsv_d, claimed_q, claimed_d, granted_d;
	logic                   in_band, fire;

	assign in_ready  = !out_valid || out_ready;
	assign fire      = in_valid && in_ready;

	assign diff      = (in_weight > ref_q) ? in_weight - ref_q : ref_q - in_weight;
	assign in_band   = CW'(diff) <= CW'(cfg.jump_threshold);
	assign start_eff = bsv_q ? start_q : in_now;

	always_comb begin
		state_d   = state_q;
		ref_d     = ref_q;
		held_d    = held_q;
		start_d   = start_q;
		bsv_d     = bsv_q;
		claimed_d = claimed_q;
		granted_d = 1'b0;
		if (in_upd) begin
			unique case (state_q)
				S_IDLE: begin
					if (CW'(in_weight) > CW'(cfg.presence_level)) begin
						state_d = S_MEASURING;
					end
				end
				S_MEASURING: begin
					if (in_band) begin
						start_d = start_eff;
						bsv_d   = 1'b1;
						if (TIME_W'(in_now - start_eff) >= TIME_W'(cfg.hold_time)) begin
							state_d = S_STABLE;
							held_d  = in_weight;
						end
					end else begin
						ref_d   = in_weight;
						start_d = in_now;
						bsv_d   = 1'b1;
					end
				end
				S_STABLE: begin
					state_d   = S_WAIT;
					claimed_d = 1'b0;
				end
				S_WAIT: begin
					if (CW'(in_weight) < CW'(cfg.noise_floor)) begin
						state_d = S_IDLE;
						ref_d   = '0;
						start_d = '0;
						bsv_d   = 1'b0;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end else if (in_op == OP_CLAIM && state_q == S_WAIT && !claimed_q) begin
			granted_d = 1'b1;
			claimed_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			ref_q           <= '0;
			held_q          <= '0;
			start_q         <= '0;
			bsv_q           <= 1'b0;
			claimed_q       <= 1'b0;
			out_valid       <= 1'b0;
			smoothed_weight <= '0;
			machine_state   <= MS_IDLE;
			holding         <= 1'b0;
			item_granted    <= 1'b0;
			item_weight     <= '0;
		end else begin
			if (in_ready) begin
				out_valid <= in_valid;
			end
			if (fire) begin
				state_q         <= state_d;
				ref_q           <= ref_d;
				held_q          <= held_d;
				start_q         <= start_d;
				bsv_q           <= bsv_d;
				claimed_q       <= claimed_d;
				smoothed_weight <= in_weight;
				machine_state   <= state_d;
				holding         <= (state_d == S_STABLE) || (state_d == S_WAIT);
				item_granted    <= granted_d;
				item_weight     <= granted_d ? held_q : '0;
			end
		end
	end

endmodule

[rtl/core/weight_stability_detector_core.sv]
// ----------------------------------------------------------------------------
// weight_stability_detector_core
// Load-cell sample filter with stable-load detection and one-shot claim.
// ----------------------------------------------------------------------------
// Pipeline: input reg, ring/sum, mean, gate, smoothing, result reg; a result
//   moves on through them in order, held only under back-pressure.
// Throughput: one item per cycle unless m_tready stalls; running sum, accepted
//   mean and smoothing accumulator each close their loop within a single stage.
// Reset: arst_n clears all control state and config registers to defaults at once;
//   the sample ring needs no clearing pass, unfilled slots read as zero.
// ----------------------------------------------------------------------------
module weight_stability_detector_core import wsd_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	localparam int OUT_DATA_W = ((2 * WEIGHT_BITS + 4 + 7) / 8) * 8,
	localparam int IDX_W      = $clog2(WINDOW_LENGTH),
	localparam int SUM_W      = WEIGHT_BITS + IDX_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sample_weight[23:0], now_ms[55:24]
	input  logic [0:0]            s_tuser,   // op[0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// smoothed_weight, machine_state, holding, item_granted, item_weight, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// configuration write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers; writes land in the cycle after cfg_valid, never stall.
	// ------------------------------------------------------------------
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jump_threshold  <= JUMP_RST;
			cfg_q.smoothing_alpha <= ALPHA_RST;
			cfg_q.hold_time       <= HOLD_RST;
			cfg_q.noise_floor     <= FLOOR_RST;
			cfg_q.presence_level  <= PRESENCE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_JUMP_THRESHOLD:  cfg_q.jump_threshold  <= cfg_data[JUMP_W-1:0];
				CFG_SMOOTHING_ALPHA: cfg_q.smoothing_alpha <= cfg_data[ALPHA_W-1:0];
				CFG_HOLD_TIME:       cfg_q.hold_time       <= cfg_data[LEVEL_W-1:0];
				CFG_NOISE_FLOOR:     cfg_q.noise_floor     <= cfg_data[LEVEL_W-1:0];
				CFG_PRESENCE_LEVEL:  cfg_q.presence_level  <= cfg_data[LEVEL_W-1:0];
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1-2: input register, clamp, ring and running sum.
	// ------------------------------------------------------------------
	logic              r_valid, r_ready, r_upd;
	op_t               r_op;
	logic [SUM_W-1:0]  r_sum;
	logic [TIME_W-1:0] r_now;

	wsd_ring #(
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tuser[0])),
		.in_weight (s_tdata[SAMPLE_W-1:0]),
		.in_now    (s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.out_op    (r_op),
		.out_upd   (r_upd),
		.out_sum   (r_sum),
		.out_now   (r_now)
	);

	// ------------------------------------------------------------------
	// Stage 3-5: mean, noise/jump gate, exponential smoothing.
	// r_upd marks a sample taken once the ring has filled; only those
	// move the filter and the machine.
	// ------------------------------------------------------------------
	logic                   f_valid, f_ready, f_upd;
	op_t                    f_op;
	logic [WEIGHT_BITS-1:0] f_weight;
	logic [TIME_W-1:0]      f_now;

	wsd_filter #(
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (r_valid),
		.in_ready   (r_ready),
		.in_op      (r_op),
		.in_upd     (r_upd),
		.in_sum     (r_sum),
		.in_now     (r_now),
		.out_valid  (f_valid),
		.out_ready  (f_ready),
		.out_op     (f_op),
		.out_upd    (f_upd),
		.out_weight (f_weight),
		.out_now    (f_now)
	);

	// ------------------------------------------------------------------
	// State machine, claim, result register. The result register takes a new item
	// as the previous result leaves, and holds its input off while that result waits for m_tready.
	// ------------------------------------------------------------------
	logic [WEIGHT_BITS-1:0] smoothed_weight, item_weight;
	logic [1:0]             machine_state;
	logic                   holding, item_granted;

	wsd_fsm #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_fsm (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (f_valid),
		.in_ready        (f_ready),
		.in_op           (f_op),
		.in_upd          (f_upd),
		.in_weight       (f_weight),
		.in_now          (f_now),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.smoothed_weight (smoothed_weight),
		.machine_state   (machine_state),
		.holding         (holding),
		.item_granted    (item_granted),
		.item_weight     (item_weight)
	);

	// fields packed from bit 0 up, zero filled to whole bytes
	assign m_tdata = OUT_DATA_W'({item_weight, item_granted, holding, machine_state,
		smoothed_weight});

endmodule

[rtl/core/wsd_checker.sv]
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
module wsd_checker import wsd_pkg::*; #(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	localparam int OUT_DATA_W = ((2 * WEIGHT_BITS + 4 + 7) / 8) * 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int ST_LO   = WEIGHT_BITS;
	localparam int HOLD_B  = WEIGHT_BITS + 2;
	localparam int GRANT_B = WEIGHT_BITS + 3;
	localparam int ITEM_LO = WEIGHT_BITS + 4;

	logic [1:0]             st;
	logic                   hold_f, grant_f;
	logic [WEIGHT_BITS-1:0] item;

	assign st      = m_tdata[ST_LO+1:ST_LO];
	assign hold_f  = m_tdata[HOLD_B];
	assign grant_f = m_tdata[GRANT_B];
	assign item    = m_tdata[ITEM_LO+WEIGHT_BITS-1:ITEM_LO];

	// stalled result stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_holding: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hold_f == (st == MS_STABLE || st == MS_WAIT)))
		else $error("holding disagrees with machine_state");

	// a grant is only given out while waiting for removal
	a_grant_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && grant_f |-> st == MS_WAIT)
		else $error("item granted outside wait-for-remove");

	a_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !grant_f |-> item == '0)
		else $error("item_weight nonzero without grant");

endmodule

bind weight_stability_detector_core wsd_checker #(
	.WEIGHT_BITS(WEIGHT_BITS)
) u_wsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[bench/tb_weight_stability_detector_core.sv]
// ----------------------------------------------------------------------------
// tb_weight_stability_detector_core
// Self-checking bench for the load-cell filter and stable-load detector.
// Samples and claims go in on the input stream. A software copy of the ring
// mean, the jump gate, the smoothing and the load state machine predicts each
// result not typed in a directed row; each result transfer is compared field
// by field. Six register settings are run, the extremes among them, with random
// idling on both sides, a long output hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module tb_weight_stability_detector_core;
	import wsd_pkg::*;

	// limit on the length of the whole run
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned IDLE_PCT    = 26;
	localparam int unsigned HOLD_OFF    = 80;
	localparam int          WEIGHT_MAX  = 8388607;
	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

	// result fields, lowest bit last in the list
	typedef struct packed {
		logic [22:0] item_weight;
		logic        item_granted;
		logic        holding;
		logic [1:0]  machine_state;
		logic [22:0] smoothed_weight;
	} reading_t;

	typedef struct packed {
		op_t         op;
		logic [23:0] raw;
		logic [31:0] now;
		logic        typed;   // want holds the result to check; else predicted
		reading_t    want;
	} dir_row_t;

	localparam reading_t EMPTY_IDLE = '{item_weight: 23'd0, item_granted: 1'b0,
		holding: 1'b0, machine_state: MS_IDLE, smoothed_weight: 23'd0};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// detector copy: registers
	logic [19:0] thr_jump;
	logic [16:0] alpha_q;
	logic [15:0] hold_ms;
	logic [15:0] floor_lvl;
	logic [15:0] presence_lvl;
	// detector copy: filter and machine state
	logic [22:0] win_buf [WINDOW_LENGTH_DEF];
	logic [3:0]  win_pos;
	logic        win_full;
	logic [26:0] win_total;
	logic [22:0] kept_mean;
	logic [38:0] ema_acc;
	logic [1:0]  load_state;
	logic [22:0] anchor_w;
	logic [31:0] band_t0;
	logic        band_t0_ok;
	logic [22:0] hold_w;
	logic        handed_out;

	reading_t    pending_readings [$];
	dir_row_t    dir_rows [25];
	reading_t    seen;
	reading_t    due;
	int unsigned fail_count   = 0;
	int unsigned items_sent   = 0;
	int unsigned cycle_count  = 0;
	int unsigned tx_idle_pct  = IDLE_PCT;
	int unsigned rx_idle_pct  = IDLE_PCT;
	bit          rx_hold_req  = 1'b0;
	logic [31:0] now_clk      = 32'd0;

	weight_stability_detector_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [22:0] weight_gap(input logic [22:0] a, input logic [22:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// One input item through the filter and the load machine; returns its result.
	function automatic reading_t advance_detector(input op_t op, input logic [23:0] raw,
			input logic [31:0] now);
		reading_t    r;
		logic [22:0] s;
		logic [22:0] mean;
		logic [22:0] w;
		logic [63:0] a;
		logic [63:0] mix;
		r = '0;
		if (op == OP_SAMPLE) begin
			// negative samples clamp to zero; 23 bits cannot overflow the max
			s = raw[23] ? 23'd0 : raw[22:0];
			win_total = win_total - 27'(win_buf[win_pos]) + 27'(s);
			win_buf[win_pos] = s;
			if (win_pos == 4'(WINDOW_LENGTH_DEF - 1))
				win_full = 1'b1;
			win_pos = win_pos + 4'd1;
			// nothing past the ring moves until it has filled once
			if (win_full) begin
				mean = 23'(win_total / WINDOW_LENGTH_DEF);
				a = (alpha_q > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_q);
				if (mean < floor_lvl)
					mean = '0;
				if (kept_mean == '0 || weight_gap(mean, kept_mean) <= thr_jump)
					kept_mean = mean;
				mix = a * {25'd0, kept_mean, 16'd0} + (64'(ALPHA_ONE) - a) * 64'(ema_acc)
					+ 64'(HALF_LSB);
				ema_acc = 39'(mix >> 16);
				w = ema_acc[38:16];
				case (load_state)
					MS_IDLE: begin
						if (w > presence_lvl)
							load_state = MS_MEASURING;
					end
					MS_MEASURING: begin
						if (weight_gap(w, anchor_w) <= thr_jump) begin
							if (!band_t0_ok) begin
								band_t0    = now;
								band_t0_ok = 1'b1;
							end
							// wrapping elapsed time
							if (32'(now - band_t0) >= hold_ms) begin
								load_state = MS_STABLE;
								hold_w     = w;
							end
						end else begin
							anchor_w   = w;
							band_t0    = now;
							band_t0_ok = 1'b1;
						end
					end
					MS_STABLE: begin
						load_state = MS_WAIT;
						handed_out = 1'b0;
					end
					default: begin
						if (w < floor_lvl) begin
							load_state = MS_IDLE;
							anchor_w   = '0;
							band_t0    = '0;
							band_t0_ok = 1'b0;
						end
					end
				endcase
			end
		end else if (load_state == MS_WAIT && !handed_out) begin
			// one grant per load
			r.item_granted = 1'b1;
			r.item_weight  = hold_w;
			handed_out     = 1'b1;
		end
		r.smoothed_weight = ema_acc[38:16];
		r.machine_state   = load_state;
		r.holding         = (load_state == MS_STABLE || load_state == MS_WAIT);
		return r;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// result side: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = reading_t'(m_tdata[$bits(reading_t)-1:0]);
			if (pending_readings.size() == 0) begin
				$error("result transfer with nothing pending: %h", m_tdata);
				fail_count++;
			end else begin
				due = pending_readings.pop_front();
				check_field("smoothed_weight", due.smoothed_weight, seen.smoothed_weight);
				check_field("machine_state", due.machine_state, seen.machine_state);
				check_field("holding", due.holding, seen.holding);
				check_field("item_granted", due.item_granted, seen.item_granted);
				check_field("item_weight", due.item_weight, seen.item_weight);
			end
		end
	end

	// result side ready: random stalls, plus a long hold-off on request
	initial begin : rx_side
		int unsigned hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = HOLD_OFF;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Entered and left at a falling edge; one input transfer.
	task automatic send_item(input op_t op, input logic [23:0] raw, input logic [31:0] now,
			input logic typed, input reading_t typed_want);
		reading_t model_out;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {now, raw};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		model_out = advance_detector(op, raw, now);
		pending_readings.push_back(typed ? typed_want : model_out);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_readings.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_JUMP_THRESHOLD:  thr_jump     = data[19:0];
			CFG_SMOOTHING_ALPHA: alpha_q      = data[16:0];
			CFG_HOLD_TIME:       hold_ms      = data[15:0];
			CFG_NOISE_FLOOR:     floor_lvl    = data[15:0];
			CFG_PRESENCE_LEVEL:  presence_lvl = data[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// all five registers, only once the block has gone quiet
	task automatic load_settings(input logic [19:0] jump, input logic [16:0] alpha,
			input logic [15:0] hold, input logic [15:0] flr, input logic [15:0] presence,
			input bit with_spares);
		logic [CFG_IDX_W-1:0] idx;
		wait_for_drain();
		repeat (8) @(negedge clk);
		write_reg(CFG_JUMP_THRESHOLD, jump);
		write_reg(CFG_SMOOTHING_ALPHA, 20'(alpha));
		write_reg(CFG_HOLD_TIME, 20'(hold));
		write_reg(CFG_NOISE_FLOOR, 20'(flr));
		write_reg(CFG_PRESENCE_LEVEL, 20'(presence));
		if (with_spares) begin
			for (idx = CFG_SPARE_FIRST; idx != CFG_SPARE_LAST; idx++)
				write_reg(idx, 20'($urandom));
			write_reg(CFG_SPARE_LAST, 20'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] advance_clock_ms();
		// mostly short steps, now and then a long gap
		if ($urandom_range(99) < 5)
			now_clk = now_clk + $urandom_range(1000, 70000);
		else
			now_clk = now_clk + $urandom_range(0, 120);
		return now_clk;
	endfunction

	task automatic send_claim();
		send_item(OP_CLAIM, 24'($urandom), $urandom, 1'b0, EMPTY_IDLE);
	endtask

	// one load: put on, settle, claim, take off
	task automatic present_load();
		int load_w;
		int span;
		int spread;
		int v;
		int k;
		span = (thr_jump > 20'd15000) ? 200000 : 14 * int'(thr_jump) + 40;
		load_w = int'(floor_lvl) + int'(presence_lvl) + int'($urandom_range(20, span));
		if ($urandom_range(9) == 0)
			load_w = int'($urandom_range(0, WEIGHT_MAX));
		if (load_w > WEIGHT_MAX)
			load_w = WEIGHT_MAX;
		spread = (int'(thr_jump) / 4 > 50) ? 50 : int'(thr_jump) / 4;
		for (k = $urandom_range(18, 32); k > 0; k--) begin
			if ($urandom_range(99) < 12) begin
				send_claim();
			end else begin
				v = load_w + int'($urandom_range(0, 2 * spread)) - spread;
				if (v > WEIGHT_MAX)
					v = WEIGHT_MAX;
				send_item(OP_SAMPLE, 24'(v), advance_clock_ms(), 1'b0, EMPTY_IDLE);
			end
		end
		repeat ($urandom_range(1, 3))
			send_claim();
		// removal: small readings around zero, some negative
		for (k = $urandom_range(17, 24); k > 0; k--) begin
			if ($urandom_range(99) < 8) begin
				send_claim();
			end else begin
				if ($urandom_range(99) < 30)
					v = -int'($urandom_range(1, 4000));
				else
					v = int'($urandom_range(0, floor_lvl / 2));
				send_item(OP_SAMPLE, 24'(v), advance_clock_ms(), 1'b0, EMPTY_IDLE);
			end
		end
	endtask

	task automatic run_phase(input int unsigned n);
		int unsigned goal;
		goal = items_sent + n;
		while (items_sent < goal) begin
			if ($urandom_range(99) < 12)
				send_item(op_t'($urandom_range(1)), 24'($urandom), $urandom, 1'b0, EMPTY_IDLE);
			else
				present_load();
		end
	endtask

	initial begin : stimulus
		int k;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		// detector copy at reset
		thr_jump     = JUMP_RST;
		alpha_q      = ALPHA_RST;
		hold_ms      = HOLD_RST;
		floor_lvl    = FLOOR_RST;
		presence_lvl = PRESENCE_RST;
		for (k = 0; k < WINDOW_LENGTH_DEF; k++)
			win_buf[k] = '0;
		win_pos    = '0;
		win_full   = 1'b0;
		win_total  = '0;
		kept_mean  = '0;
		ema_acc    = '0;
		load_state = MS_IDLE;
		anchor_w   = '0;
		band_t0    = '0;
		band_t0_ok = 1'b0;
		hold_w     = '0;
		handed_out = 1'b0;

		// directed rows; until the ring fills every result is all zero in idle
		dir_rows[0]  = '{OP_CLAIM,  24'h000000, 32'h00000000, 1'b1, EMPTY_IDLE};
		dir_rows[1]  = '{OP_SAMPLE, 24'h7FFFFF, 32'h00000000, 1'b1, EMPTY_IDLE};
		dir_rows[2]  = '{OP_SAMPLE, 24'h800000, 32'hFFFFFFFF, 1'b1, EMPTY_IDLE};
		dir_rows[3]  = '{OP_SAMPLE, 24'hFFFFFF, 32'd10,       1'b1, EMPTY_IDLE};
		dir_rows[4]  = '{OP_CLAIM,  24'h7FFFFF, 32'hFFFFFFFF, 1'b1, EMPTY_IDLE};
		for (k = 5; k <= 16; k++)
			dir_rows[k] = '{OP_SAMPLE, 24'd1000, 32'(100 * k), 1'b1, EMPTY_IDLE};
		// from here on the predictor supplies the result
		dir_rows[17] = '{OP_SAMPLE, 24'd1000,   32'd1700,     1'b0, EMPTY_IDLE};
		dir_rows[18] = '{OP_SAMPLE, 24'd1000,   32'd1800,     1'b0, EMPTY_IDLE};
		dir_rows[19] = '{OP_CLAIM,  24'h000000, 32'h00000000, 1'b0, EMPTY_IDLE};
		dir_rows[20] = '{OP_SAMPLE, 24'h555555, 32'hAAAAAAAA, 1'b0, EMPTY_IDLE};
		dir_rows[21] = '{OP_SAMPLE, 24'h2AAAAA, 32'h55555555, 1'b0, EMPTY_IDLE};
		dir_rows[22] = '{OP_SAMPLE, 24'h000000, 32'h80000000, 1'b0, EMPTY_IDLE};
		dir_rows[23] = '{OP_SAMPLE, 24'd1000,   32'h80000064, 1'b0, EMPTY_IDLE};
		dir_rows[24] = '{OP_CLAIM,  24'hFFFFFF, 32'hFFFFFFFF, 1'b0, EMPTY_IDLE};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < 25; k++)
			send_item(dir_rows[k].op, dir_rows[k].raw, dir_rows[k].now,
				dir_rows[k].typed, dir_rows[k].want);

		// low extremes: a wide jump band, no smoothing, instant hold
		load_settings(20'd1000000, ALPHA_ONE, 16'd0, 16'd0, 16'd0, 1'b0);
		run_phase(65);

		// reset values again; long output hold-off midway to back up the input
		load_settings(JUMP_RST, ALPHA_RST, HOLD_RST, FLOOR_RST, PRESENCE_RST, 1'b0);
		run_phase(30);
		rx_hold_req = 1'b1;
		run_phase(40);

		// high extremes, all bits set; time wraps early in this phase
		load_settings(20'hFFFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		now_clk = 32'hFFFFF000;
		run_phase(30);
		wait_for_drain();
		run_phase(30);

		// zero band, frozen smoothing, no idling at all on either side
		load_settings(20'd0, 17'd0, 16'd200, 16'd40, 16'd80, 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(65);
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;

		// random setting, with writes to the unused indexes
		k = $urandom_range(0, 200);
		load_settings(20'($urandom_range(100, 3000)), 17'($urandom_range(1, 17'h1FFFF)),
			16'($urandom_range(0, 1000)), 16'(k), 16'(k + $urandom_range(0, 300)), 1'b1);
		run_phase(65);

		wait_for_drain();
		repeat (12) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
